### rtl/core/lrut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache hit tracker package
// Shared widths, reset values, channel item types and cell control group.
// ----------------------------------------------------------------------------
package lrut_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int CAP_W   = 5;

    // Defaults for the top level parameters.
    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam int DEFAULT_KEY_BITS    = 32;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Counter value at which the totals stop counting.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One input item.
    typedef struct packed {
        logic [KEY_W-1:0] access_key;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [KEY_W-1:0]   evicted_key;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] access_total;
    } out_item_t;

    // Control broadcast from the top level to every cell of the stack.
    typedef struct packed {
        logic step;   // an item is accepted in this cycle
        logic hit;    // the probe key matched some cell
        logic evict;  // the stack is at or above capacity, so a miss drops the tail
    } cell_ctrl_t;

endpackage

### rtl/core/lrut_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache hit tracker stream channel
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface lrut_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

### rtl/core/lrut_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache hit tracker stack cell
// One position of the recency stack: holds a key and its valid bit, compares
// the probe key and takes its left neighbour's entry when the stack shifts.
// ----------------------------------------------------------------------------
module lrut_cell #(
    parameter int SK = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lrut_pkg::cell_ctrl_t ctrl,
    input  logic [SK-1:0]       probe_key,
    input  logic [SK-1:0]       left_key,
    input  logic                left_valid,
    input  logic                right_valid,
    input  logic                seen_in,
    output logic                seen_out,
    output logic [SK-1:0]       key,
    output logic                valid,
    output logic                tail
);

    logic [SK-1:0] key_reg;
    logic          valid_reg;
    logic          match;
    logic          load;

    // Match on this cell; the seen flag tells whether the hit lies here or
    // further towards the least recently used end.
    assign match    = valid_reg && (key_reg == probe_key);
    assign seen_out = match | seen_in;

    // On a hit, every cell up to the hit position shifts. On a miss with
    // eviction, all valid cells shift and the tail entry falls out. On a miss
    // without eviction, the stack grows by one cell.
    always_comb
    begin
        if (!ctrl.step)
        begin
            load = 1'b0;
        end
        else if (ctrl.hit)
        begin
            load = seen_out;
        end
        else if (ctrl.evict)
        begin
            load = valid_reg;
        end
        else
        begin
            load = left_valid;
        end
    end

    // Key store: no reset, it is only looked at where valid is set.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= left_key;
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= left_valid;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

### rtl/core/lru_cache_hit_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache hit tracker core
// Fully associative LRU cache model built as a recency-ordered stack of cells.
// ----------------------------------------------------------------------------
// Each item on access_in carries one access key. For every accepted item one
// result item appears on result_out: the hit flag, the evicted key with its
// valid flag, and the saturating hit and access totals including this item.
// The cells are kept in recency order, most recently used first, so a hit
// shifts the cells up to the hit position and a miss shifts the whole stack,
// dropping the tail entry when occupancy has reached the capacity.
// The result is valid in the cycle after acceptance, and one item is taken
// every cycle unless the receiver stalls: the tag compare, the hit position
// chain and the stack shift all complete within the accepting cycle.
// The result sits in an output register; a new item is accepted whenever the
// register is empty or its item is taken in the same cycle, so a stalled
// receiver holds the result and stops acceptance until it is taken.
// Reset empties the stack, clears both totals and sets the capacity to its
// reset value. cfg_we writes the capacity; zero acts as one, values above
// the built entry count act as that count.
// ----------------------------------------------------------------------------
module lru_cache_hit_tracker_core #(
    parameter int MAX_ENTRIES = lrut_pkg::DEFAULT_MAX_ENTRIES,
    parameter int KEY_BITS    = lrut_pkg::DEFAULT_KEY_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lrut_pkg::CAP_W-1:0] cfg_wdata,
    lrut_stream_if.sink                access_in,
    lrut_stream_if.source              result_out
);

    // Stored key width: keys are compared on their low KEY_BITS bits.
    localparam int SK    = (KEY_BITS < lrut_pkg::KEY_W) ? KEY_BITS : lrut_pkg::KEY_W;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lrut_pkg::CAP_W) ? OCC_W : lrut_pkg::CAP_W;

    logic [lrut_pkg::CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic [lrut_pkg::COUNT_W-1:0] hit_cnt_reg;
    logic [lrut_pkg::COUNT_W-1:0] hit_cnt_next;
    logic [lrut_pkg::COUNT_W-1:0] acc_cnt_reg;
    logic [lrut_pkg::COUNT_W-1:0] acc_cnt_next;
    logic                         out_valid_reg;
    lrut_pkg::out_item_t          out_item_reg;
    lrut_pkg::out_item_t          out_item_next;

    logic                         step;
    logic                         hit;
    logic                         evict;
    logic [CMP_W-1:0]             cap_ext;
    logic [CMP_W-1:0]             eff_cap;
    logic [SK-1:0]                probe_key;
    logic [SK-1:0]                tail_key;
    lrut_pkg::cell_ctrl_t         ctrl;

    logic [SK-1:0]                cell_key [MAX_ENTRIES];
    logic [MAX_ENTRIES:0]         cell_valid;
    logic [MAX_ENTRIES:0]         seen;
    logic [MAX_ENTRIES-1:0]       cell_tail;

    // Handshake: take an item while the output register is free or emptying.
    assign access_in.ready = !out_valid_reg || result_out.ready;
    assign step            = access_in.valid && access_in.ready;
    assign probe_key       = access_in.data.access_key[SK-1:0];

    // Effective capacity and the eviction condition.
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict = CMP_W'(occ_reg) >= eff_cap;
    assign hit   = seen[0];

    assign ctrl.step  = step;
    assign ctrl.hit   = hit;
    assign ctrl.evict = evict;

    // The stack ends: nothing beyond the last cell.
    assign seen[MAX_ENTRIES]       = 1'b0;
    assign cell_valid[MAX_ENTRIES] = 1'b0;

    // Row of cells, most recently used at index zero.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [SK-1:0] left_key;
        logic          left_valid;

        if (i == 0)
        begin : g_head
            assign left_key   = probe_key;
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_key   = cell_key[i-1];
            assign left_valid = cell_valid[i-1];
        end

        lrut_cell #(
            .SK (SK)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .probe_key   (probe_key),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .right_valid (cell_valid[i+1]),
            .seen_in     (seen[i+1]),
            .seen_out    (seen[i]),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    // The tail cell is the least recently used entry; exactly one is marked
    // when the stack is not empty.
    always_comb
    begin
        tail_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tail_key = tail_key | (cell_key[i] & {SK{cell_tail[i]}});
        end
    end

    // Counter and occupancy updates for the accepted item.
    always_comb
    begin
        acc_cnt_next = (acc_cnt_reg == lrut_pkg::COUNT_MAX) ? acc_cnt_reg
                                                            : acc_cnt_reg + 1'b1;
        hit_cnt_next = hit_cnt_reg;
        if (hit && (hit_cnt_reg != lrut_pkg::COUNT_MAX))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
        occ_next = occ_reg;
        if (!hit && !evict)
        begin
            occ_next = occ_reg + 1'b1;
        end
    end

    // Result item for the accepted item.
    always_comb
    begin
        out_item_next.hit           = hit;
        out_item_next.evicted_valid = !hit && evict;
        out_item_next.evicted_key   = (!hit && evict) ? lrut_pkg::KEY_W'(tail_key)
                                                      : '0;
        out_item_next.hit_total     = hit_cnt_next;
        out_item_next.access_total  = acc_cnt_next;
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lrut_pkg::CAPACITY_RESET;
            occ_reg       <= '0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (step)
            begin
                occ_reg     <= occ_next;
                hit_cnt_reg <= hit_cnt_next;
                acc_cnt_reg <= acc_cnt_next;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_item_reg;

endmodule

### tb/lru_cache_hit_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache hit tracker core testbench
// Streams access keys through the core under several capacity settings and
// checks every result item against a behavioural LRU cache kept alongside.
// ----------------------------------------------------------------------------
// A directed opening covers the key extremes, hits, misses, eviction at full
// occupancy, a capacity lowered below occupancy, and capacities of zero and
// above the built entry count. Random phases follow, each at a new capacity,
// drawing keys mostly from a small working set so that hits and evictions
// are frequent. The sender works in bursts and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module lru_cache_hit_tracker_core_tb;

    localparam int ENTRIES    = lrut_pkg::DEFAULT_MAX_ENTRIES;
    localparam int PHASE_ITEMS = 155;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [lrut_pkg::CAP_W-1:0] cfg_wdata;

    lrut_stream_if #(.payload_t(lrut_pkg::in_item_t))  access_ch ();
    lrut_stream_if #(.payload_t(lrut_pkg::out_item_t)) result_ch ();

    lru_cache_hit_tracker_core #(
        .MAX_ENTRIES (ENTRIES),
        .KEY_BITS    (lrut_pkg::DEFAULT_KEY_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .access_in  (access_ch),
        .result_out (result_ch)
    );

    // Behavioural cache state: keys, valid flags and ages (0 is most recent).
    logic [lrut_pkg::KEY_W-1:0]   cache_keys  [ENTRIES];
    logic                         cache_valid [ENTRIES];
    int                           cache_age   [ENTRIES];
    int                           cache_fill;
    logic [lrut_pkg::COUNT_W-1:0] hit_tally;
    logic [lrut_pkg::COUNT_W-1:0] access_tally;
    logic [lrut_pkg::CAP_W-1:0]   capacity_reg;

    lrut_pkg::in_item_t  access_queue[$];
    lrut_pkg::out_item_t predicted_results[$];
    int                  mismatch_count;

    // Sender burst state and receiver stall pattern.
    int burst_left;
    int gap_left;
    int stall_period;
    int stall_pct;

    always #6 clk = ~clk;

    // Capacity as the core applies it: zero acts as one, large values clamp.
    function automatic int effective_capacity(input logic [lrut_pkg::CAP_W-1:0] cap);
        if (cap == '0)
            return 1;
        if (int'(cap) > ENTRIES)
            return ENTRIES;
        return int'(cap);
    endfunction

    // Look up one key in the behavioural cache and queue the expected result.
    task automatic predict_lookup(input logic [lrut_pkg::KEY_W-1:0] key);
        lrut_pkg::out_item_t res;
        int                  slot;
        int                  victim;
        int                  age_hit;
        res  = '0;
        slot = -1;
        access_tally = (access_tally == lrut_pkg::COUNT_MAX) ? access_tally
                                                             : access_tally + 1'b1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && cache_valid[i] && cache_keys[i] == key)
                slot = i;
        if (slot >= 0)
        begin
            // Hit: entries more recent than this one age by one.
            res.hit   = 1'b1;
            hit_tally = (hit_tally == lrut_pkg::COUNT_MAX) ? hit_tally : hit_tally + 1'b1;
            age_hit   = cache_age[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (cache_valid[i] && cache_age[i] < age_hit)
                    cache_age[i]++;
            cache_age[slot] = 0;
        end
        else
        begin
            // Miss at capacity: the oldest entry makes room.
            if (cache_fill >= effective_capacity(capacity_reg))
            begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (cache_valid[i] && (victim < 0 || cache_age[i] > cache_age[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    res.evicted_valid   = 1'b1;
                    res.evicted_key     = cache_keys[victim];
                    cache_valid[victim] = 1'b0;
                    slot                = victim;
                end
            end
            if (slot < 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !cache_valid[i])
                        slot = i;
                if (slot >= 0)
                    cache_fill++;
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (cache_valid[i])
                        cache_age[i]++;
                cache_keys[slot]  = key;
                cache_valid[slot] = 1'b1;
                cache_age[slot]   = 0;
            end
        end
        res.hit_total    = hit_tally;
        res.access_total = access_tally;
        predicted_results.insert(predicted_results.size(), res);
    endtask

    // Sender: items leave the queue in bursts separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            access_ch.valid <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else
        begin
            if (access_ch.valid && access_ch.ready)
                predict_lookup(access_ch.data.access_key);
            if (!access_ch.valid || access_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    access_ch.valid <= 1'b0;
                    gap_left        <= gap_left - 1;
                end
                else if (access_queue.size() != 0)
                begin
                    access_ch.valid <= 1'b1;
                    access_ch.data  <= access_queue[0];
                    access_queue.delete(0);
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    access_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall rate changes every so often, sometimes to none.
    always @(posedge clk)
    begin
        if (stall_period == 0)
        begin
            stall_period <= $urandom_range(40, 200);
            case ($urandom_range(0, 4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 25;
                3:       stall_pct <= 50;
                default: stall_pct <= 80;
            endcase
        end
        else
            stall_period <= stall_period - 1;
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker: each item taken is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        lrut_pkg::out_item_t want;
        lrut_pkg::out_item_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with none expected: %p", $realtime, got);
            end
            else
            begin
                want = predicted_results[0];
                predicted_results.delete(0);
                if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
                    got.evicted_key !== want.evicted_key ||
                    got.hit_total !== want.hit_total ||
                    got.access_total !== want.access_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    // Wait until every queued item has been accepted and its result arrived.
    task automatic wait_drained();
        @(negedge clk);
        while (access_queue.size() != 0 || access_ch.valid ||
               predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // Capacity writes happen only while the core is idle.
    task automatic write_capacity(input logic [lrut_pkg::CAP_W-1:0] value);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        capacity_reg = value;
        @(negedge clk);
    endtask

    task automatic queue_key(input logic [lrut_pkg::KEY_W-1:0] key);
        lrut_pkg::in_item_t item;
        item.access_key = key;
        access_queue.insert(access_queue.size(), item);
    endtask

    // One random phase: mostly a working set around the capacity, in random
    // order or as a cyclic sweep, with some stray keys mixed in.
    task automatic queue_random_phase(input int count);
        logic [lrut_pkg::KEY_W-1:0] pool[$];
        int                         pool_n;
        int                         sweep;
        int                         pos;
        int                         roll;
        logic [lrut_pkg::KEY_W-1:0] key;
        pool_n = $urandom_range(1, effective_capacity(capacity_reg) + 4);
        sweep  = ($urandom_range(0, 3) == 0);
        pos    = 0;
        for (int i = 0; i < pool_n; i++)
            pool.insert(pool.size(), $urandom());
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                if (sweep)
                begin
                    key = pool[pos];
                    pos = (pos + 1) % pool_n;
                end
                else
                    key = pool[$urandom_range(0, pool_n - 1)];
            end
            else if (roll < 95)
                key = $urandom();
            else if (roll < 97)
                key = ($urandom_range(0, 1) == 0) ? '0 : '1;
            else
            begin
                // Shift the working set by replacing one of its keys.
                key = $urandom();
                pool[$urandom_range(0, pool_n - 1)] = key;
            end
            queue_key(key);
        end
    endtask

    // Main sequence: reset, directed opening, random phases, final verdict.
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = lrut_pkg::CAPACITY_RESET;
        access_ch.valid    = 1'b0;
        access_ch.data     = '0;
        result_ch.ready    = 1'b0;
        stall_period       = 0;
        stall_pct          = 0;
        mismatch_count     = 0;
        cache_fill         = 0;
        hit_tally          = '0;
        access_tally       = '0;
        capacity_reg       = lrut_pkg::CAPACITY_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_keys[i]  = '0;
            cache_valid[i] = 1'b0;
            cache_age[i]   = 0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Key extremes, repeat hits, then fill the cache and force an eviction.
        queue_key('0);
        queue_key('1);
        queue_key('0);
        queue_key('1);
        for (int i = 1; i <= 14; i++)
            queue_key({4'(i), 24'h5A5A5A, 4'(15 - i)});
        queue_key('0);
        queue_key(32'h1234_5678);
        wait_drained();

        // Capacity lowered well below occupancy: misses evict but keep the fill.
        write_capacity(5'd4);
        queue_key(32'hAAAA_AAAA);
        queue_key(32'h5555_5555);
        queue_key(32'h1234_5678);
        wait_drained();

        // Zero capacity acts as one entry.
        write_capacity(5'd0);
        queue_key(32'h8000_0000);
        queue_key(32'h8000_0000);
        queue_key(32'h0000_0001);
        wait_drained();

        // Capacity above the built entry count clamps to it.
        write_capacity(5'd31);
        queue_key(32'hDEAD_BEEF);
        queue_key('1);
        wait_drained();

        // Random phases across a spread of capacities, extremes included.
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:       write_capacity(5'd1);
                1:       write_capacity(5'd16);
                2:       write_capacity(5'd2);
                3:       write_capacity(5'd0);
                4:       write_capacity(5'd31);
                5:       write_capacity(5'd17);
                6:       write_capacity(5'd8);
                default: write_capacity(5'($urandom_range(0, 31)));
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (predicted_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial
    begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
